@@ design/pidm_pkg.sv @@
`default_nettype none

package pidm_pkg;

  // operand and product widths of the shared multiplier
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // width of the shared divider (dividend, divisor and quotient)
  localparam int DIV_W   = 24;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int SPEED_W = 20;
  localparam int ERR_W   = 21;
  localparam int DIFF_W  = 22;
  localparam int INTEG_W = 32;
  localparam int GAIN_W  = 16;
  localparam int DUTY_W  = 8;
  localparam int PULSE_W = 8;
  localparam int MS_W    = 16;

  localparam int PULSES_PER_TURN = 20;
  localparam int MS_PER_MINUTE   = 60000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

@@ design/pid_motor_speed_loop.sv @@
`default_nettype none

// Speed loop for one motor. Each request carries the encoder pulse count and
// the milliseconds since the last tick; the block measures the speed as
// pulses*60000/(ms*20) in RPM (saturated), forms the error against target_rpm,
// adds error*ms to a saturating 32-bit integral, takes (error - last error)/ms
// truncated toward zero as derivative, and sums the three Q8.8 gain terms into
// a 0..255 duty. Each request makes two passes through the bit-serial
// divider (24 quotient bits each, speed then derivative) with sequencing
// around the shared registered multiplier, then returns to idle to take
// the next request; requests are handled one at a time. Input is taken
// only while the loop is idle; the result sits in an output register, so
// the next request can start while it waits, and a request that finishes
// while the previous result is still waiting holds until it is taken.
// Writing target_rpm clears the integral and the last error; configuration
// writes belong between requests.
module pid_motor_speed_loop (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] pulse_count, [23:8] elapsed_ms
  input  wire  [23:0]                         s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // [19:0] speed_rpm, [40:20] speed_error, [48:41] drive_duty,
  // [49] drive_forward, [55:50] zero
  output logic [55:0]                         m_axis_tdata,
  input  wire                                 cfg_we,
  input  wire  [pidm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [pidm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pidm_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NUM   = 4'd1;
  localparam logic [3:0] ST_DEN   = 4'd2;
  localparam logic [3:0] ST_SDIV  = 4'd3;
  localparam logic [3:0] ST_SWAIT = 4'd4;
  localparam logic [3:0] ST_EMUL  = 4'd5;
  localparam logic [3:0] ST_INT   = 4'd6;
  localparam logic [3:0] ST_DWAIT = 4'd7;
  localparam logic [3:0] ST_PTERM = 4'd8;
  localparam logic [3:0] ST_ITERM = 4'd9;
  localparam logic [3:0] ST_DTERM = 4'd10;
  localparam logic [3:0] ST_SUM   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [3:0] state;

  // configuration
  logic [SPEED_W-1:0]       target_rpm;
  logic                     run_forward;
  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_d;

  // loop state
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   last_error;

  // per-request working registers
  logic [PULSE_W-1:0]        pulses;
  logic [MS_W-1:0]           ms;
  logic [DIV_W-1:0]          num;
  logic [SPEED_W-1:0]        speed;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W-1:0] integ;
  logic signed [DIFF_W-1:0]  deriv;
  logic                      dneg;
  logic signed [PROD_W-1:0]  acc;

  // shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [DIV_W-1:0]          div_divisor;
  logic [DIV_W-1:0]          div_q;
  div_stat_t                 div_st;

  logic signed [ERR_W-1:0]   err_next;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic signed [INTEG_W+5:0] integ_wide;
  logic signed [INTEG_W-1:0] integ_next;
  logic [SPEED_W-1:0]        speed_next;
  logic [DUTY_W-1:0]         duty;
  logic                      out_free;

  pidm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pidm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_st)
  );

  assign err_next = ERR_W'($signed({1'b0, target_rpm}) - $signed({1'b0, speed}));
  assign diff     = DIFF_W'(err_next) - DIFF_W'(last_error);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;

  // integral update with saturation to 32 bits
  assign integ_wide = (INTEG_W+6)'(integral_sum) + (INTEG_W+6)'(prod[INTEG_W+5:0]);
  always_comb begin
    if (integ_wide[INTEG_W+5:INTEG_W-1] == '0 || integ_wide[INTEG_W+5:INTEG_W-1] == '1) begin
      integ_next = integ_wide[INTEG_W-1:0];
    end else if (integ_wide[INTEG_W+5]) begin
      integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  // zero elapsed time: full scale when any pulse came in
  always_comb begin
    if (ms == '0) begin
      speed_next = (pulses != '0) ? SPEED_MAX : '0;
    end else if (div_q > DIV_W'(SPEED_MAX)) begin
      speed_next = SPEED_MAX;
    end else begin
      speed_next = div_q[SPEED_W-1:0];
    end
  end

  always_comb begin
    if (acc[PROD_W-1] || acc == '0) begin
      duty = '0;
    end else if (acc[PROD_W-1:16] != '0) begin
      duty = '1;
    end else begin
      duty = acc[15:8];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_NUM: begin
        mul_a = MUL_A_W'(pulses);
        mul_b = MUL_B_W'(MS_PER_MINUTE);
      end
      ST_DEN: begin
        mul_a = MUL_A_W'(ms);
        mul_b = MUL_B_W'(PULSES_PER_TURN);
      end
      ST_EMUL: begin
        mul_a = MUL_A_W'(err_next);
        mul_b = MUL_B_W'(ms);
      end
      ST_PTERM: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(gain_p);
      end
      ST_ITERM: begin
        mul_a = MUL_A_W'(integ);
        mul_b = MUL_B_W'(gain_i);
      end
      ST_DTERM: begin
        mul_a = MUL_A_W'(deriv);
        mul_b = MUL_B_W'(gain_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start    = (state == ST_SDIV) || (state == ST_EMUL);
  assign div_dividend = (state == ST_SDIV) ? num : DIV_W'(diff_mag);
  assign div_divisor  = (state == ST_SDIV) ? prod[DIV_W-1:0] : DIV_W'(ms);

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      target_rpm    <= '0;
      run_forward   <= 1'b0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      integral_sum  <= '0;
      last_error    <= '0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:  if (s_axis_tvalid) state <= ST_NUM;
        ST_NUM:   state <= ST_DEN;
        ST_DEN:   state <= ST_SDIV;
        ST_SDIV:  state <= ST_SWAIT;
        ST_SWAIT: if (div_st.done) state <= ST_EMUL;
        ST_EMUL:  state <= ST_INT;
        ST_INT:   state <= ST_DWAIT;
        ST_DWAIT: if (div_st.done) state <= ST_PTERM;
        ST_PTERM: state <= ST_ITERM;
        ST_ITERM: state <= ST_DTERM;
        ST_DTERM: state <= ST_SUM;
        ST_SUM:   state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            integral_sum  <= integ;
            last_error    <= err;
            state         <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
      // register writes come last so a setpoint write always clears the loop state
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET: begin
            target_rpm   <= cfg_data[SPEED_W-1:0];
            integral_sum <= '0;
            last_error   <= '0;
          end
          REG_FORWARD: run_forward <= cfg_data[0];
          REG_GAIN_P:  gain_p <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:  gain_i <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:  gain_d <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pulses <= s_axis_tdata[PULSE_W-1:0];
        ms     <= s_axis_tdata[PULSE_W+MS_W-1:PULSE_W];
      end
      ST_DEN: num <= prod[DIV_W-1:0];
      ST_SWAIT: if (div_st.done) speed <= speed_next;
      ST_EMUL: begin
        err  <= err_next;
        dneg <= diff[DIFF_W-1];
      end
      ST_INT: integ <= integ_next;
      ST_DWAIT: begin
        if (div_st.done) begin
          // truncation toward zero: divide the magnitude, then restore the sign
          if (ms == '0) begin
            deriv <= '0;
          end else if (dneg) begin
            deriv <= -$signed(div_q[DIFF_W-1:0]);
          end else begin
            deriv <= $signed(div_q[DIFF_W-1:0]);
          end
        end
      end
      ST_ITERM: acc <= prod;
      ST_DTERM: acc <= acc + prod;
      ST_SUM:   acc <= acc + prod;
      ST_OUT: begin
        if (out_free) begin
          m_axis_tdata <= {6'd0, run_forward, duty, err, speed};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_SWAIT || state == ST_DWAIT))
    else $error("divider finished outside a wait state");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  a_setpoint_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == REG_TARGET) |=> (integral_sum == '0 && last_error == '0))
    else $error("setpoint write left loop state behind");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> (m_axis_tvalid && state == ST_IDLE))
    else $error("result not presented");
`endif

endmodule

`default_nettype wire

@@ design/pidm_mul.sv @@
`default_nettype none

module pidm_mul (
  input  wire                                   clk,
  input  wire signed [pidm_pkg::MUL_A_W-1:0]    a,
  input  wire signed [pidm_pkg::MUL_B_W-1:0]    b,
  output logic signed [pidm_pkg::PROD_W-1:0]    prod
);
  import pidm_pkg::*;

  // one signed product per cycle, registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

@@ design/pidm_div.sv @@
`default_nettype none

module pidm_div (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire [pidm_pkg::DIV_W-1:0]         dividend,
  input  wire [pidm_pkg::DIV_W-1:0]         divisor,
  output logic [pidm_pkg::DIV_W-1:0]        quotient,
  output pidm_pkg::div_stat_t               stat
);
  import pidm_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dsor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_W:0]       shifted;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsor     <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(shifted - {1'b0, dsor});
      end else begin
        rem <= shifted[DIV_W-1:0];
      end
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import pidm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  // one result, laid out as in m_axis_tdata[49:0]
  typedef struct packed {
    logic              fwd;
    logic [DUTY_W-1:0] duty;
    logic [ERR_W-1:0]  err;
    logic [SPEED_W-1:0] speed;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PULSE_W-1:0] pulses;
    logic [MS_W-1:0]    ms;
    logic               typed;
    tick_result_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pid_motor_speed_loop i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // loop state mirrored by the predictor
  logic [SPEED_W-1:0]        set_rpm = '0;
  logic                      set_fwd = 1'b0;
  logic signed [GAIN_W-1:0]  kp = '0;
  logic signed [GAIN_W-1:0]  ki = '0;
  logic signed [GAIN_W-1:0]  kd = '0;
  logic signed [INTEG_W-1:0] integ_acc = '0;
  logic signed [ERR_W-1:0]   prev_err = '0;

  tick_result_t pending_ticks[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  dir_row_t dir_rows [30];

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic tick_result_t compute_tick(input logic [PULSE_W-1:0] p,
                                                input logic [MS_W-1:0] ms);
    longint num, den, q, err, acc, deriv, sum, whole;
    tick_result_t r;
    num = longint'(p) * MS_PER_MINUTE;
    den = longint'(ms) * PULSES_PER_TURN;
    if (den == 0) begin
      q = (p != 0) ? longint'(SPEED_MAX) : 0;
    end else begin
      q = num / den;
      if (q > longint'(SPEED_MAX)) q = longint'(SPEED_MAX);
    end
    err = longint'(set_rpm) - q;
    acc = longint'(integ_acc) + err * longint'(ms);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    integ_acc = acc[INTEG_W-1:0];
    // zero elapsed time gives no derivative
    deriv = 0;
    if (ms != 0) deriv = (err - longint'(prev_err)) / longint'(ms);
    prev_err = err[ERR_W-1:0];
    sum = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * deriv;
    if (sum <= 0) begin
      r.duty = '0;
    end else begin
      whole = sum >>> 8;
      r.duty = (whole > 255) ? 8'd255 : whole[DUTY_W-1:0];
    end
    r.speed = q[SPEED_W-1:0];
    r.err = err[ERR_W-1:0];
    r.fwd = set_fwd;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [3:0] top;
    logic [GAIN_W-1:0] g;
    top = 4'($urandom);
    case ($urandom_range(0, 4))
      0: g = 16'h7FFF;
      1: g = 16'h8000;
      2: g = 16'h0000;
      3: g = 16'($urandom_range(0, 1023)) - 16'd512;
      default: g = 16'($urandom);
    endcase
    return {top, g};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TARGET: begin
        set_rpm = data;
        integ_acc = '0;
        prev_err = '0;
      end
      REG_FORWARD: set_fwd = data[0];
      REG_GAIN_P:  kp = data[GAIN_W-1:0];
      REG_GAIN_I:  ki = data[GAIN_W-1:0];
      REG_GAIN_D:  kd = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic [PULSE_W-1:0] p, input logic [MS_W-1:0] ms,
                           input logic use_typed, input tick_result_t typed_res);
    tick_result_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ms, p};
    do @(posedge clk); while (!s_axis_tready);
    res = compute_tick(p, ms);
    pending_ticks.push_back(use_typed ? typed_res : res);
  endtask

  task automatic random_tick();
    logic [PULSE_W-1:0] p;
    logic [MS_W-1:0] ms;
    case ($urandom_range(0, 7))
      0: p = 8'd0;
      1: p = 8'd255;
      default: p = 8'($urandom);
    endcase
    case ($urandom_range(0, 39))
      0: ms = 16'd0;
      1, 2, 3, 4, 5: ms = 16'hFFFF;
      6, 7, 8, 9, 10, 11, 12, 13, 14, 15: ms = 16'($urandom);
      default: ms = 16'($urandom_range(1, 300));
    endcase
    push_tick(p, ms, 1'b0, '0);
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tick_result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = tick_result_t'(m_axis_tdata[49:0]);
      if (pending_ticks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: tdata %h", m_axis_tdata);
      end else begin
        want = pending_ticks.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch (exp/act): speed %0d/%0d err %0d/%0d duty %0d/%0d fwd %0b/%0b",
                     want.speed, got.speed, $signed(want.err), $signed(got.err),
                     want.duty, got.duty, want.fwd, got.fwd);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pid_motor_speed_loop regression: fail");
      $finish;
    end
  end

  initial begin
    int n;
    // result fields in each row: fwd, duty, err, speed
    dir_rows = '{
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd1, 1'b1, '{1'b0, 8'd0, 21'd0, 20'd0}},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd255, 16'd1, 1'b1,
        '{1'b0, 8'd0, -21'sd765000, 20'd765000}},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd1, 16'd0, 1'b1,
        '{1'b0, 8'd0, -21'sd1048575, 20'd1048575}},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd0, 1'b1, '{1'b0, 8'd0, 21'd0, 20'd0}},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd255, 16'd65535, 1'b1,
        '{1'b0, 8'd0, -21'sd11, 20'd11}},
      '{ROW_CFG, REG_TARGET, 20'hFFFFF, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_FORWARD, 20'h00001, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_GAIN_P, 20'h07FFF, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd1, 1'b1,
        '{1'b1, 8'd255, 21'd1048575, 20'd0}},
      '{ROW_CFG, REG_GAIN_P, 20'hF8000, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd1, 1'b1,
        '{1'b1, 8'd0, 21'd1048575, 20'd0}},
      '{ROW_CFG, REG_TARGET, 20'd100, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_GAIN_P, 20'h00100, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd1, 1'b1, '{1'b1, 8'd100, 21'd100, 20'd0}},
      '{ROW_CFG, REG_GAIN_D, 20'h00400, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd255, 16'd1, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd7, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd3, 16'd10, 1'b0, '0},
      '{ROW_CFG, REG_UNUSED_5, 20'hFFFFF, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_UNUSED_7, 20'h00000, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd1, 1'b0, '0},
      '{ROW_CFG, REG_FORWARD, 20'h00000, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_GAIN_P, 20'h00000, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_GAIN_D, 20'h00000, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_GAIN_I, 20'h07FFF, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_CFG, REG_TARGET, 20'hFFFFF, 8'd0, 16'd0, 1'b0, '0},
      // integral pinned at its positive limit
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd65535, 1'b1,
        '{1'b0, 8'd255, 21'd1048575, 20'd0}},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd65535, 1'b0, '0},
      '{ROW_CFG, REG_GAIN_I, 20'h08000, 8'd0, 16'd0, 1'b0, '0},
      '{ROW_TICK, REG_TARGET, 20'd0, 8'd0, 16'd1, 1'b1, '{1'b0, 8'd0, 21'd1048575, 20'd0}}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else push_tick(dir_rows[i].pulses, dir_rows[i].ms, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases, each with random register writes before its ticks
    for (int ph = 0; ph < 20; ph++) begin
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_TARGET, 20'd0);
          1: write_reg(REG_TARGET, 20'hFFFFF);
          2: write_reg(REG_TARGET, 20'($urandom_range(0, 4000)));
          default: write_reg(REG_TARGET, 20'($urandom));
        endcase
      end
      if ($urandom_range(0, 1)) write_reg(REG_FORWARD, 20'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_GAIN_P, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_GAIN_I, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_GAIN_D, pick_gain());
      if ($urandom_range(0, 5) == 0)
        write_reg(3'($urandom_range(REG_UNUSED_5, REG_UNUSED_7)), 20'($urandom));
      n = $urandom_range(20, 60);
      repeat (n) random_tick();
    end

    // steady reverse error pulls the integral far below zero
    write_reg(REG_TARGET, 20'd0);
    write_reg(REG_GAIN_I, pick_gain());
    repeat (100) push_tick(8'd255, 16'($urandom_range(1, 3)), 1'b0, '0);

    // last stretch: no idling on either side
    write_reg(REG_TARGET, 20'($urandom_range(0, 4000)));
    write_reg(REG_GAIN_P, pick_gain());
    calm = 1'b1;
    repeat (100) random_tick();
    s_axis_tvalid <= 1'b0;

    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_motor_speed_loop regression: pass");
    end else begin
      $display("pid_motor_speed_loop regression: fail");
    end
    $finish;
  end

endmodule
